### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the scanline unfilter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, clocked on the rising edge and held off during reset.
`define PUF_ASSERT(lbl, clk_s, rstn_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
        else $error("puf assertion failed");

// A condition that must never hold out of reset.
`define PUF_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
    `PUF_ASSERT(lbl, clk_s, rstn_s, !(cond))

`endif

### hw/rtl/puf_pkg.sv
// ---------------------------------------------------------------------------
// puf_pkg
// Types, codes and helper functions of the PNG scanline unfilter.
// ---------------------------------------------------------------------------
`default_nettype none

package puf_pkg;

    localparam int PUF_MAX_ROW_PIXELS  = 4096;
    localparam int PUF_MAX_IMAGE_ROWS  = 16384;
    localparam int PUF_QUEUE_DEPTH     = 2;
    localparam int PUF_CFG_DATA_W      = 15;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROW_PIXELS  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_ROWS  = 2'd1;
    localparam logic [1:0] CFG_PIXEL_BYTES = 2'd2;

    // PNG filter types.
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    typedef struct packed {
        logic [12:0] row_pixels;
        logic [14:0] image_rows;
        logic [2:0]  pixel_bytes;
    } cfg_t;

    // One classified byte on its way from the front to the back.
    typedef struct packed {
        logic [7:0] raw;
        logic       is_sample;
        logic [2:0] filt;
        logic       use_a;      // a left neighbour exists in this row
        logic       use_b;      // a row above exists in this image
        logic       bad;
        logic       eor;
        logic       eoi;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_sample;
        logic       bad_filter;
        logic       end_of_row;
        logic       end_of_image;
    } result_t;

    // Bytes per pixel minus one, with zero read as one and anything above four as four.
    function automatic logic [1:0] bpp_index(input logic [2:0] pb);
        logic [1:0] idx;
        if (pb == 3'd0) begin
            idx = 2'd0;
        end
        else if (pb > 3'd4) begin
            idx = 2'd3;
        end
        else begin
            idx = 2'(pb - 3'd1);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/png_scanline_unfilter_top.sv
// ---------------------------------------------------------------------------
// png_scanline_unfilter_top
// PNG scanline filter reconstruction (none, sub, up, average, Paeth) on a
// byte stream, with a line store holding the previous row.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Transfer when            Payload
//  -------   ---------  -----------------------  ---------------------------------
//  input     in         push && !full            raw_byte
//  result    out        pop && !empty            out_byte, is_sample, bad_filter,
//                                                end_of_row, end_of_image
//  config    in         wr_en (index 0..2)       wr_index, wr_data
//
//  One byte is taken in every cycle while the front queue has room, and one result
//  is produced for every byte. A byte passes through the front queue, then the
//  back stage, where the line store read returns, then the output queue.
//  The line store is a single RAM of four bytes per pixel of the widest row,
//  written once and read once per sample; reset leaves it unwritten, so no
//  clearing pass is needed and the block is ready as soon as reset is released.
//  Either side may stall freely: the front queue and the output queue let the
//  front keep taking bytes while a finished result waits to be popped.
//
`default_nettype none

module png_scanline_unfilter_top import puf_pkg::*; #(
    parameter int MAX_ROW_PIXELS = PUF_MAX_ROW_PIXELS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Input queue side
    input  wire logic                      push,
    input  wire logic [7:0]                raw_byte,
    output logic                           full,
    // Result queue side
    input  wire logic                      pop,
    output logic                           empty,
    output logic      [7:0]                out_byte,
    output logic                           is_sample,
    output logic                           bad_filter,
    output logic                           end_of_row,
    output logic                           end_of_image,
    // Configuration write port
    input  wire logic                      wr_en,
    input  wire logic [1:0]                wr_index,
    input  wire logic [PUF_CFG_DATA_W-1:0] wr_data
);

    // Configuration registers. Writes to an index beyond the list are ignored.
    logic [12:0] row_pixels_reg;
    logic [14:0] image_rows_reg;
    logic [2:0]  pixel_bytes_reg;
    cfg_t        cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pixels_reg  <= 13'd1;
            image_rows_reg  <= 15'd1;
            pixel_bytes_reg <= 3'd4;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_ROW_PIXELS:  row_pixels_reg  <= wr_data[12:0];
                CFG_IMAGE_ROWS:  image_rows_reg  <= wr_data[14:0];
                CFG_PIXEL_BYTES: pixel_bytes_reg <= wr_data[2:0];
                default:         ;
            endcase
        end
    end

    assign cfg.row_pixels  = row_pixels_reg;
    assign cfg.image_rows  = image_rows_reg;
    assign cfg.pixel_bytes = pixel_bytes_reg;

    // The front classifies each byte and pushes it into a short queue; the back
    // drains that queue, does the arithmetic and fills the output queue.
    logic    mq_push, mq_full, mq_pop, mq_empty;
    item_t   mq_wr_item, mq_rd_item;
    logic    oq_push, oq_full;
    result_t oq_wr_res, oq_rd_res;

    puf_front #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .raw_byte (raw_byte),
        .full     (full),
        .q_full   (mq_full),
        .q_push   (mq_push),
        .q_item   (mq_wr_item)
    );

    puf_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (PUF_QUEUE_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mq_push),
        .wr_data (mq_wr_item),
        .full    (mq_full),
        .pop     (mq_pop),
        .rd_data (mq_rd_item),
        .empty   (mq_empty)
    );

    puf_back #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (mq_empty),
        .q_item  (mq_rd_item),
        .q_pop   (mq_pop),
        .o_full  (oq_full),
        .o_push  (oq_push),
        .o_res   (oq_wr_res)
    );

    puf_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (PUF_QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (oq_push),
        .wr_data (oq_wr_res),
        .full    (oq_full),
        .pop     (pop),
        .rd_data (oq_rd_res),
        .empty   (empty)
    );

    assign out_byte     = oq_rd_res.out_byte;
    assign is_sample    = oq_rd_res.is_sample;
    assign bad_filter   = oq_rd_res.bad_filter;
    assign end_of_row   = oq_rd_res.end_of_row;
    assign end_of_image = oq_rd_res.end_of_image;

endmodule

`default_nettype wire

### hw/rtl/puf_ram.sv
// ---------------------------------------------------------------------------
// puf_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module puf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/puf_fifo.sv
// ---------------------------------------------------------------------------
// puf_fifo
// Small register queue used between the front and back and at the output.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module puf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push_ok, pop_ok;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `PUF_ASSERT_NEVER(a_fifo_overfill, clk, rst_n, count_reg > CW'(DEPTH))
    `PUF_ASSERT(a_fifo_grow, clk, rst_n, (push_ok && !pop_ok) |=> (count_reg == CW'($past(count_reg) + 1'b1)))

endmodule

`default_nettype wire

### hw/rtl/puf_front.sv
// ---------------------------------------------------------------------------
// puf_front
// Tracks row and image position, decodes filter type bytes and tags each byte.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module puf_front import puf_pkg::*; #(
    parameter int MAX_ROW_PIXELS = PUF_MAX_ROW_PIXELS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       push,
    input  wire logic [7:0] raw_byte,
    output logic            full,
    input  wire logic       q_full,
    output logic            q_push,
    output item_t           q_item
);

    localparam int PX_W  = $clog2(MAX_ROW_PIXELS + 1);
    localparam int POS_W = $clog2(MAX_ROW_PIXELS * 4 + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [13:0]      row_cnt_reg, row_cnt_next;
    logic [2:0]       filt_reg, filt_next;
    logic             first_row_reg, first_row_next;
    logic             err_reg, err_next;

    logic [31:0]      px_wide;
    logic [PX_W-1:0]  px;
    logic [POS_W-1:0] px_ext;
    logic [POS_W-1:0] row_len;
    logic [1:0]       bpp_idx;
    logic [2:0]       bpp;
    logic [14:0]      rows;
    logic             last_byte, last_row, accept;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept;

    // Effective geometry with out-of-range settings clamped.
    always_comb
    begin
        px_wide = 32'(cfg.row_pixels);
        if (px_wide == 32'd0)
        begin
            px_wide = 32'd1;
        end
        else if (px_wide > 32'(MAX_ROW_PIXELS))
        begin
            px_wide = 32'(MAX_ROW_PIXELS);
        end
        px      = PX_W'(px_wide);
        px_ext  = POS_W'(px);
        bpp_idx = bpp_index(cfg.pixel_bytes);
        bpp     = 3'({1'b0, bpp_idx} + 3'd1);
        case (bpp_idx)
            2'd0:    row_len = px_ext;
            2'd1:    row_len = POS_W'(px_ext << 1);
            2'd2:    row_len = POS_W'((px_ext << 1) + px_ext);
            default: row_len = POS_W'(px_ext << 2);
        endcase
        if (cfg.image_rows == 15'd0)
        begin
            rows = 15'd1;
        end
        else if (32'(cfg.image_rows) > 32'(PUF_MAX_IMAGE_ROWS))
        begin
            rows = 15'(PUF_MAX_IMAGE_ROWS);
        end
        else
        begin
            rows = cfg.image_rows;
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        row_cnt_next   = row_cnt_reg;
        filt_next      = filt_reg;
        first_row_next = first_row_reg;
        err_next       = err_reg;
        last_byte      = (pos_reg >= row_len);
        last_row       = ({1'b0, row_cnt_reg} + 15'd1) >= rows;

        q_item.raw       = raw_byte;
        q_item.is_sample = 1'b1;
        q_item.filt      = filt_reg;
        q_item.use_a     = (pos_reg > POS_W'(bpp));
        q_item.use_b     = !first_row_reg;
        q_item.bad       = err_reg;
        q_item.eor       = last_byte;
        q_item.eoi       = last_byte && last_row;

        if (pos_reg == '0)
        begin
            // Filter type byte: an unknown type latches the error and runs as none.
            if (raw_byte > 8'(FILT_PAETH))
            begin
                err_next  = 1'b1;
                filt_next = FILT_NONE;
            end
            else
            begin
                filt_next = raw_byte[2:0];
            end
            q_item.is_sample = 1'b0;
            q_item.bad       = err_next;
            q_item.eor       = 1'b0;
            q_item.eoi       = 1'b0;
            pos_next         = POS_W'(1);
        end
        else if (last_byte)
        begin
            pos_next = '0;
            if (last_row)
            begin
                row_cnt_next   = '0;
                first_row_next = 1'b1;
                err_next       = 1'b0;
            end
            else
            begin
                row_cnt_next   = 14'(row_cnt_reg + 14'd1);
                first_row_next = 1'b0;
            end
        end
        else
        begin
            pos_next = POS_W'(pos_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            row_cnt_reg   <= '0;
            filt_reg      <= FILT_NONE;
            first_row_reg <= 1'b1;
            err_reg       <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            row_cnt_reg   <= row_cnt_next;
            filt_reg      <= filt_next;
            first_row_reg <= first_row_next;
            err_reg       <= err_next;
        end
    end

    `PUF_ASSERT(a_err_clears_at_image_end, clk, rst_n, (accept && q_item.eoi) |=> (!err_reg && first_row_reg && (pos_reg == '0)))

endmodule

`default_nettype wire

### hw/rtl/puf_back.sv
// ---------------------------------------------------------------------------
// puf_back
// Reads the line store, rebuilds each sample and writes it back for the next row.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module puf_back import puf_pkg::*; #(
    parameter int MAX_ROW_PIXELS = PUF_MAX_ROW_PIXELS
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    q_empty,
    input  wire item_t   q_item,
    output logic         q_pop,
    input  wire logic    o_full,
    output logic         o_push,
    output result_t      o_res
);

    localparam int DEPTH = MAX_ROW_PIXELS * 4;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          r_valid_reg, r_valid_next;
    item_t         r_item_reg;
    logic [AW-1:0] r_addr_reg;
    logic [AW-1:0] idx_reg, idx_next;
    logic [31:0]   left_reg, left_next;
    logic [31:0]   upleft_reg, upleft_next;

    logic          load, fire;
    logic [7:0]    above;
    logic [7:0]    a, b, c, pred, v;
    logic [1:0]    bpp_idx;
    logic [4:0]    sel;
    logic [8:0]    ab_sum;

    function automatic logic [7:0] paeth(input logic [7:0] pa, input logic [7:0] pb,
                                         input logic [7:0] pc);
        logic [7:0] da, db;
        logic [8:0] s, cc, dc;
        logic [7:0] res;
        da = (pb > pc) ? 8'(pb - pc) : 8'(pc - pb);
        db = (pa > pc) ? 8'(pa - pc) : 8'(pc - pa);
        s  = {1'b0, pa} + {1'b0, pb};
        cc = {pc, 1'b0};
        dc = (s > cc) ? 9'(s - cc) : 9'(cc - s);
        if (({1'b0, da} <= {1'b0, db}) && ({1'b0, da} <= dc))
        begin
            res = pa;
        end
        else if ({1'b0, db} <= dc)
        begin
            res = pb;
        end
        else
        begin
            res = pc;
        end
        return res;
    endfunction

    assign fire   = r_valid_reg && !o_full;
    assign load   = !q_empty && (!r_valid_reg || fire);
    assign q_pop  = load;
    assign o_push = fire;

    puf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (fire && r_item_reg.is_sample),
        .wr_addr (r_addr_reg),
        .wr_data (v),
        .rd_en   (load && q_item.is_sample),
        .rd_addr (idx_reg),
        .rd_data (above)
    );

    always_comb
    begin
        bpp_idx = bpp_index(cfg.pixel_bytes);
        sel     = {bpp_idx, 3'b000};
        a       = r_item_reg.use_a ? left_reg[sel +: 8] : 8'd0;
        b       = r_item_reg.use_b ? above : 8'd0;
        c       = (r_item_reg.use_a && r_item_reg.use_b) ? upleft_reg[sel +: 8] : 8'd0;
        ab_sum  = {1'b0, a} + {1'b0, b};
        case (r_item_reg.filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth(a, b, c);
            default:    pred = 8'd0;
        endcase
        v = 8'(r_item_reg.raw + pred);

        o_res.out_byte     = r_item_reg.is_sample ? v : 8'd0;
        o_res.is_sample    = r_item_reg.is_sample;
        o_res.bad_filter   = r_item_reg.bad;
        o_res.end_of_row   = r_item_reg.eor;
        o_res.end_of_image = r_item_reg.eoi;
    end

    always_comb
    begin
        r_valid_next = r_valid_reg;
        idx_next     = idx_reg;
        left_next    = left_reg;
        upleft_next  = upleft_reg;
        if (fire)
        begin
            r_valid_next = 1'b0;
            if (r_item_reg.is_sample)
            begin
                left_next   = {left_reg[23:0], v};
                upleft_next = {upleft_reg[23:0], b};
            end
            else
            begin
                left_next   = '0;
                upleft_next = '0;
            end
        end
        if (load)
        begin
            r_valid_next = 1'b1;
            idx_next     = q_item.is_sample ? AW'(idx_reg + 1'b1) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            idx_reg     <= '0;
            left_reg    <= '0;
            upleft_reg  <= '0;
        end
        else
        begin
            r_valid_reg <= r_valid_next;
            idx_reg     <= idx_next;
            left_reg    <= left_next;
            upleft_reg  <= upleft_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_item_reg <= q_item;
            r_addr_reg <= idx_reg;
        end
    end

    `PUF_ASSERT(a_stall_holds, clk, rst_n, (r_valid_reg && o_full) |=> (r_valid_reg && $stable(r_item_reg) && $stable(left_reg)))

endmodule

`default_nettype wire

### bench/png_scanline_unfilter_top_tb.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top_tb
// Self-checking bench for the PNG scanline unfilter. Raster bytes are pushed
// through the input queue while a predictor of the block works out each
// reconstructed byte and its flags. Every popped result is compared field by
// field with the oldest expectation. A short directed table comes first, then
// random images under several row, row-count and pixel-size settings.
// ----------------------------------------------------------------------------

module png_scanline_unfilter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import puf_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no transfer on either side
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int SEGS_PER_RUN = 10;     // configuration segments per idling pattern
    localparam int STORE_BYTES  = PUF_MAX_ROW_PIXELS * 4;

    // Smallest filter type byte that is not a valid PNG filter.
    localparam logic [7:0] FILT_FIRST_BAD = 8'(FILT_PAETH) + 8'd1;

    // Kinds of entry in the directed table.
    typedef enum logic {STEP_BYTE, STEP_CFG} step_kind_e;

    typedef struct packed {
        step_kind_e  kind;
        logic [12:0] px;        // configuration entries only
        logic [14:0] rows;
        logic [2:0]  bpp;
        logic [7:0]  raw;       // byte entries only
        logic        typed;     // expectation written out below, not predicted
        result_t     want;
    } dir_step_t;

    // Result of a valid or of a bad filter type byte.
    localparam result_t FILT_BYTE_OK  = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam result_t FILT_BYTE_BAD = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0};

    localparam int DIR_STEPS = 23;

    // The block starts with one pixel of four bytes per row and one row per
    // image, so the first rows are four samples long and end the image each
    // time. The first image passes bytes straight through at the extremes,
    // the second carries a bad filter type and must raise the sticky flag from
    // its filter byte to its last sample. Then a two by four image of single
    // byte pixels runs sub, up, average and Paeth rows over the line store.
    localparam dir_step_t DIRECTED [DIR_STEPS] = '{
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'(FILT_NONE), 1'b1, FILT_BYTE_OK},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h80, 1'b1, '{8'h80, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h7F, 1'b1, '{8'h7F, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, FILT_FIRST_BAD, 1'b1, FILT_BYTE_BAD},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h01, 1'b1, '{8'h01, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'hFE, 1'b1, '{8'hFE, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h55, 1'b1, '{8'h55, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'hAA, 1'b1, '{8'hAA, 1'b1, 1'b1, 1'b1, 1'b1}},
        '{STEP_CFG,  13'd2, 15'd4, 3'd1, 8'h00, 1'b0, '0},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'(FILT_SUB), 1'b1, FILT_BYTE_OK},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'hF0, 1'b1, '{8'hF0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h20, 1'b0, '0},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'(FILT_UP), 1'b1, FILT_BYTE_OK},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h10, 1'b0, '0},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'hFF, 1'b0, '0},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'(FILT_AVG), 1'b1, FILT_BYTE_OK},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h81, 1'b0, '0},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h03, 1'b0, '0},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'(FILT_PAETH), 1'b1, FILT_BYTE_OK},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h7F, 1'b0, '0},
        '{STEP_BYTE, 13'd0, 15'd0, 3'd0, 8'h80, 1'b0, '0}
    };

    // Widest settings, one set per idling pattern; all of them saturate or sit
    // on the upper limit, and together they set every bit of the write data.
    localparam logic [12:0] WIDE_PX   [3] = '{13'd8191, 13'd4096, 13'd4097};
    localparam logic [14:0] WIDE_ROWS [3] = '{15'd32767, 15'd16384, 15'd16385};
    localparam logic [2:0]  WIDE_BPP  [3] = '{3'd7, 3'd4, 3'd5};

    logic                      clk   = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      push;
    logic [7:0]                raw_byte;
    logic                      full;
    logic                      pop;
    logic                      empty;
    logic [7:0]                out_byte;
    logic                      is_sample;
    logic                      bad_filter;
    logic                      end_of_row;
    logic                      end_of_image;
    logic                      wr_en;
    logic [1:0]                wr_index;
    logic [PUF_CFG_DATA_W-1:0] wr_data;

    png_scanline_unfilter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .raw_byte     (raw_byte),
        .full         (full),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .is_sample    (is_sample),
        .bad_filter   (bad_filter),
        .end_of_row   (end_of_row),
        .end_of_image (end_of_image),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: the bench's own copy of the registers and of the
    // unfilter state, advanced once per accepted input byte.
    // ------------------------------------------------------------------------
    logic [12:0]  px_reg       = 13'd1;
    logic [14:0]  rows_reg     = 15'd1;
    logic [2:0]   bpp_reg      = 3'd4;

    logic [7:0]   line_mem [STORE_BYTES];
    logic [31:0]  left_hist    = '0;     // last four rebuilt bytes of this row
    logic [31:0]  above_hist   = '0;     // last four bytes read from the row above
    int unsigned  pos_in_row   = 0;      // 0 at the filter byte, then 1..row length
    int unsigned  row_in_image = 0;
    logic [2:0]   row_filt     = FILT_NONE;
    bit           top_row      = 1'b1;
    bit           bad_seen     = 1'b0;

    // Expected results in transfer order, and the bookkeeping around them.
    result_t      recon_due [$];
    int           results_due   = 0;
    int           results_seen  = 0;
    int           bytes_offered = 0;
    int           bytes_taken   = 0;
    int           n_errors      = 0;

    // What the sender offers with the byte now on the input port.
    bit           offer_typed = 1'b0;
    result_t      offer_want  = '0;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           recv_hold     = 0;

    function automatic int unsigned eff_bpp(input logic [2:0] v);
        if (v == 3'd0) return 1;
        if (v > 3'd4) return 4;
        return v;
    endfunction

    function automatic int unsigned row_len_of(input logic [12:0] px, input logic [2:0] bpp);
        int unsigned p;
        p = (px == 13'd0) ? 1 : px;
        if (p > PUF_MAX_ROW_PIXELS) p = PUF_MAX_ROW_PIXELS;
        return p * eff_bpp(bpp);
    endfunction

    // Paeth predictor: the neighbour closest to left + above - above-left,
    // ties going to left, then above.
    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int est;
        int da;
        int db;
        int dc;
        est = int'(a) + int'(b) - int'(c);
        da  = (est > int'(a)) ? est - int'(a) : int'(a) - est;
        db  = (est > int'(b)) ? est - int'(b) : int'(b) - est;
        dc  = (est > int'(c)) ? est - int'(c) : int'(c) - est;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // Rebuilds one raster byte and returns the result the block must give.
    function automatic result_t unfilter_step(input logic [7:0] raw);
        result_t     r;
        int unsigned bpp;
        int unsigned len;
        int unsigned rows;
        int unsigned idx;
        int unsigned sh;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  v;
        bit          last_byte;
        bit          last_row;

        r    = '0;
        bpp  = eff_bpp(bpp_reg);
        len  = row_len_of(px_reg, bpp_reg);
        rows = (rows_reg == 15'd0) ? 1 : rows_reg;
        if (rows > PUF_MAX_IMAGE_ROWS) rows = PUF_MAX_IMAGE_ROWS;

        if (pos_in_row == 0) begin
            // Filter type byte: a bad type raises the flag and the row passes through.
            if (raw > 8'(FILT_PAETH)) begin
                bad_seen = 1'b1;
                row_filt = FILT_NONE;
            end
            else begin
                row_filt = raw[2:0];
            end
            left_hist    = '0;
            above_hist   = '0;
            pos_in_row   = 1;
            r.bad_filter = bad_seen;
            return r;
        end

        idx = pos_in_row - 1;
        sh  = 8 * (bpp - 1);
        a   = (idx >= bpp) ? left_hist[sh +: 8] : 8'h00;
        b   = top_row ? 8'h00 : line_mem[idx];
        c   = (!top_row && idx >= bpp) ? above_hist[sh +: 8] : 8'h00;

        case (row_filt)
            FILT_SUB:   v = raw + a;
            FILT_UP:    v = raw + b;
            FILT_AVG:   v = raw + 8'((int'(a) + int'(b)) >> 1);
            FILT_PAETH: v = raw + paeth_pick(a, b, c);
            default:    v = raw;
        endcase

        line_mem[idx] = v;
        left_hist     = {left_hist[23:0], v};
        above_hist    = {above_hist[23:0], b};

        last_byte = (pos_in_row >= len);
        last_row  = (row_in_image + 1 >= rows);

        r.out_byte     = v;
        r.is_sample    = 1'b1;
        r.bad_filter   = bad_seen;
        r.end_of_row   = last_byte;
        r.end_of_image = last_byte && last_row;

        if (last_byte) begin
            pos_in_row = 0;
            if (last_row) begin
                row_in_image = 0;
                top_row      = 1'b1;
                bad_seen     = 1'b0;
            end
            else begin
                row_in_image++;
                top_row = 1'b0;
            end
        end
        else begin
            pos_in_row++;
        end
        return r;
    endfunction

    // Random raster byte shaped after where the stream stands: mostly valid
    // filter types at row starts, now and then a bad one, and samples that
    // lean on the extremes.
    function automatic logic [7:0] next_raw();
        if (pos_in_row == 0) begin
            if ($urandom_range(99) < 8) return 8'($urandom_range(FILT_FIRST_BAD, 255));
            return 8'($urandom_range(FILT_PAETH));
        end
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t MISMATCH %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Transfer monitor. Results are checked before the byte of the same edge
    // is predicted, so a result can never be matched with its own input.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n) begin
            if (pop && !empty) begin
                got = {out_byte, is_sample, bad_filter, end_of_row, end_of_image};
                results_seen++;
                if (recon_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end
                else begin
                    want = recon_due.pop_front();
                    results_due--;
                    check_field("out_byte", got.out_byte, want.out_byte);
                    check_field("is_sample", 8'(got.is_sample), 8'(want.is_sample));
                    check_field("bad_filter", 8'(got.bad_filter), 8'(want.bad_filter));
                    check_field("end_of_row", 8'(got.end_of_row), 8'(want.end_of_row));
                    check_field("end_of_image", 8'(got.end_of_image), 8'(want.end_of_image));
                end
            end
            if (push && !full) begin
                // The predictor always advances; a typed expectation replaces
                // its answer where the table gives one.
                pred = unfilter_step(raw_byte);
                recon_due.push_back(offer_typed ? offer_want : pred);
                results_due++;
                bytes_taken++;
            end
        end
    end

    // Watchdog: ends the run when neither side has transferred for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("png_scanline_unfilter_top_tb: done, errors");
        $finish;
    end

    // Result side: pops at random, or holds off for a counted stretch when the
    // stimulus asks for back-pressure.
    initial begin : result_sink
        pop <= 1'b0;
        forever begin
            @(posedge clk);
            if (recv_hold > 0) begin
                recv_hold--;
                pop <= 1'b0;
            end
            else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one byte and returns once it has been transferred and the
    // monitor has predicted it, so the predictor state is current on return.
    // Push is only lowered for an idle cycle, never between two bytes.
    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        offer_typed = typed;
        offer_want  = want;
        push     <= 1'b1;
        raw_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        bytes_offered++;
        wait (bytes_taken == bytes_offered);
    endtask

    // Waits until every expected result has been popped, then writes all
    // three registers on consecutive edges.
    task automatic load_config(input logic [12:0] px, input logic [14:0] rows,
                               input logic [2:0] bpp);
        push <= 1'b0;
        wait (results_due == 0);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= CFG_ROW_PIXELS;
        wr_data  <= PUF_CFG_DATA_W'(px);
        @(posedge clk);
        px_reg   = px;
        wr_index <= CFG_IMAGE_ROWS;
        wr_data  <= PUF_CFG_DATA_W'(rows);
        @(posedge clk);
        rows_reg = rows;
        wr_index <= CFG_PIXEL_BYTES;
        wr_data  <= PUF_CFG_DATA_W'(bpp);
        @(posedge clk);
        bpp_reg  = bpp;
        wr_en    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [12:0] px;
        logic [14:0] rows;
        logic [2:0]  bpp;
        int          n_bytes;

        push     <= 1'b0;
        raw_byte <= 8'h00;
        wr_en    <= 1'b0;
        wr_index <= CFG_ROW_PIXELS;
        wr_data  <= '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, run under the first idling pattern.
        send_idle_pct = 31;
        recv_idle_pct = 82;
        for (int i = 0; i < DIR_STEPS; i++) begin
            if (DIRECTED[i].kind == STEP_CFG)
                load_config(DIRECTED[i].px, DIRECTED[i].rows, DIRECTED[i].bpp);
            else
                send_byte(DIRECTED[i].raw, DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Random part: the receiver idles more than the sender, then the
        // other way round, then neither idles.
        for (int run = 0; run < 3; run++) begin
            send_idle_pct = (run == 0) ? 31 : (run == 1) ? 82 : 0;
            recv_idle_pct = (run == 0) ? 82 : (run == 1) ? 31 : 0;
            for (int seg = 0; seg < SEGS_PER_RUN; seg++) begin
                if (seg == 0) begin
                    // Single byte rows, one row per image.
                    px = 13'd1; rows = 15'd1; bpp = 3'd1;
                end
                else if (seg == 1) begin
                    // A wider row may only be set at the start of an image, or
                    // the next row would read line store entries never written.
                    // Zero settings close the current row and image within two
                    // bytes, however long they were.
                    load_config(13'd0, 15'd0, 3'd0);
                    while (pos_in_row != 0 || row_in_image != 0)
                        send_byte(next_raw(), 1'b0, '0);
                    px = WIDE_PX[run]; rows = WIDE_ROWS[run]; bpp = WIDE_BPP[run];
                end
                else if (seg == 2) begin
                    // Zero in every register, written mid row and mid image:
                    // the current row ends at once and so does the image.
                    px = 13'd0; rows = 15'd0; bpp = 3'd0;
                end
                else begin
                    px   = ($urandom_range(9) == 0) ? 13'($urandom_range(8191))
                                                    : 13'($urandom_range(1, 6));
                    rows = ($urandom_range(9) == 0) ? 15'($urandom)
                                                    : 15'($urandom_range(1, 5));
                    bpp  = ($urandom_range(4) == 0) ? 3'($urandom_range(7))
                                                    : 3'($urandom_range(1, 4));
                end
                // Inside an image the row may shrink but never grow.
                if ((pos_in_row != 0 || row_in_image != 0) &&
                    row_len_of(px, bpp) > row_len_of(px_reg, bpp_reg)) begin
                    px  = px_reg;
                    bpp = bpp_reg;
                end
                load_config(px, rows, bpp);

                // Once, with no idling, hold the receiver off long enough for
                // the queues to fill and the input to stall.
                if (run == 2 && seg == 3)
                    recv_hold = HOLD_CYCLES;

                n_bytes = $urandom_range(24, 50);
                repeat (n_bytes) send_byte(next_raw(), 1'b0, '0);
            end
        end

        push <= 1'b0;
        wait (results_due == 0);
        // Keep the clock running to catch any result beyond the last expected one.
        repeat (8) @(posedge clk);
        if (n_errors == 0)
            $display("png_scanline_unfilter_top_tb: done, clean");
        else
            $display("png_scanline_unfilter_top_tb: done, errors");
        $finish;
    end

endmodule
